@@ sv/imm_pkg.sv @@
// imm_pkg: sizes, request codes and controller/datapath interface types
// for the integer matrix multiply block. No dependencies.
package imm_pkg;

    localparam int DIM_MAX = 64;
    localparam int IDX_W   = $clog2(DIM_MAX);
    localparam int DIM_W   = 7;
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DEPTH   = DIM_MAX * DIM_MAX;
    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int DOT_W   = 38;

    localparam logic [1:0] REQ_LOAD_A  = 2'd0;
    localparam logic [1:0] REQ_LOAD_B  = 2'd1;
    localparam logic [1:0] REQ_COMPUTE = 2'd2;

    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             rd_en;
        logic             rd_first;
        logic             rd_last;
        logic [IDX_W-1:0] rd_row;
        logic [IDX_W-1:0] rd_k;
        logic [IDX_W-1:0] rd_col;
        logic             push;
        logic             push_last;
    } cmd_t;

    typedef struct packed {
        logic acc_full;
        logic out_free;
    } status_t;

endpackage

@@ sv/imm_ctrl.sv @@
// imm_ctrl: request decode, dimension register and row/column sequencer.
// Depends on imm_pkg.
module imm_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [6:0]              cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              req_type,
    input  logic [5:0]              row_index,
    output imm_pkg::cmd_t           cmd,
    input  imm_pkg::status_t        st
);
    import imm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [DIM_W-1:0] dim_reg;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [DIM_W-1:0] dim_eff;
    logic [IDX_W-1:0] dim_m1;
    logic             accept;
    logic             start;

    assign dim_eff  = (dim_reg > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : dim_reg;
    assign dim_m1   = IDX_W'(dim_eff - DIM_W'(1));
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign start    = accept && (req_type == REQ_COMPUTE)
                      && ({1'b0, row_index} < dim_eff);

    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        k_next        = k_reg;
        j_next        = j_reg;
        cmd           = '0;
        cmd.wr_a      = accept && (req_type == REQ_LOAD_A);
        cmd.wr_b      = accept && (req_type == REQ_LOAD_B);
        cmd.rd_row    = row_reg;
        cmd.rd_k      = k_reg;
        cmd.rd_col    = j_reg;
        cmd.push_last = (j_reg == dim_m1);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    row_next   = row_index;
                    k_next     = '0;
                    j_next     = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_first = (k_reg == '0);
                cmd.rd_last  = (k_reg == dim_m1);
                k_next       = k_reg + IDX_W'(1);
                if (k_reg == dim_m1)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (st.acc_full && st.out_free)
                begin
                    cmd.push = 1'b1;
                    k_next   = '0;
                    if (j_reg == dim_m1)
                        state_next = ST_IDLE;
                    else
                    begin
                        j_next     = j_reg + IDX_W'(1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dim_reg   <= DIM_W'(DIM_MAX);
            row_reg   <= '0;
            k_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            if (cfg_we)
                dim_reg <= cfg_wdata;
        end
    end

endmodule

@@ sv/imm_dpath.sv @@
// imm_dpath: A and B element memories, multiply-accumulate pipeline and
// result output register. Depends on imm_pkg; driven by imm_ctrl.
module imm_dpath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  imm_pkg::cmd_t           cmd,
    output imm_pkg::status_t        st,
    input  logic [5:0]              row_index,
    input  logic [5:0]              col_index,
    input  logic signed [15:0]      element_value,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [5:0]              result_row,
    output logic [5:0]              result_col,
    output logic signed [37:0]      dot_product,
    output logic                    last_of_row
);
    import imm_pkg::*;

    logic signed [ELEM_W-1:0] a_mem [DEPTH];
    logic signed [ELEM_W-1:0] b_mem [DEPTH];

    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        a_raddr;
    logic [ADDR_W-1:0]        b_raddr;
    logic signed [ELEM_W-1:0] a_rdata_reg;
    logic signed [ELEM_W-1:0] b_rdata_reg;
    logic                     v1_reg, f1_reg, l1_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     v2_reg, f2_reg, l2_reg;
    logic signed [DOT_W-1:0]  prod_ext;
    logic signed [DOT_W-1:0]  acc_reg;
    logic                     acc_full_reg;
    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_row_reg;
    logic [IDX_W-1:0]         out_col_reg;
    logic signed [DOT_W-1:0]  out_dot_reg;
    logic                     out_last_reg;

    assign wr_addr  = {row_index, col_index};
    assign a_raddr  = {cmd.rd_row, cmd.rd_k};
    assign b_raddr  = {cmd.rd_k, cmd.rd_col};
    assign prod_ext = {{(DOT_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.wr_a)
            a_mem[wr_addr] <= element_value;
        if (cmd.rd_en)
            a_rdata_reg <= a_mem[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_b)
            b_mem[wr_addr] <= element_value;
        if (cmd.rd_en)
            b_rdata_reg <= b_mem[b_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
            prod_reg <= a_rdata_reg * b_rdata_reg;
        if (v2_reg)
            acc_reg <= f2_reg ? prod_ext : acc_reg + prod_ext;
        if (cmd.push)
        begin
            out_row_reg  <= cmd.rd_row;
            out_col_reg  <= cmd.rd_col;
            out_dot_reg  <= acc_reg;
            out_last_reg <= cmd.push_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            f1_reg        <= 1'b0;
            l1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            f2_reg        <= 1'b0;
            l2_reg        <= 1'b0;
            acc_full_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.rd_en;
            f1_reg <= cmd.rd_first;
            l1_reg <= cmd.rd_last;
            v2_reg <= v1_reg;
            f2_reg <= f1_reg;
            l2_reg <= l1_reg;
            if (v2_reg && l2_reg)
                acc_full_reg <= 1'b1;
            else if (cmd.push)
                acc_full_reg <= 1'b0;
            if (cmd.push)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign st.acc_full = acc_full_reg;
    assign st.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign result_row  = out_row_reg;
    assign result_col  = out_col_reg;
    assign dot_product = out_dot_reg;
    assign last_of_row = out_last_reg;

endmodule

@@ sv/integer_matrix_multiply.sv @@
// integer_matrix_multiply: top level, joins imm_ctrl and imm_dpath.
// Depends on imm_pkg, imm_ctrl, imm_dpath.
//
// Signed 16-bit square matrix product C = A x B for sizes 1..64 (cfg_wdata,
// reset 64, values above 64 act as 64). A load request writes one element of
// A or B. A compute request for row i returns C[i][j] for j = 0..dim-1 in
// order, the last one flagged by last_of_row; a row out of range, a
// dimension of zero or request code 3 gives nothing. Each column is dim
// multiply-accumulates through one shared 16x16 multiplier, one per cycle
// fed by single-port reads of the two 4096-entry element memories, then a
// drain through the read, product and accumulator registers; in_stall is
// high for the whole row. Element memories are not cleared at reset;
// compute only over loaded entries. Configuration must be written by the
// user only while no request is in progress; the block does not enforce it.
module integer_matrix_multiply (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [6:0]          cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          req_type,
    input  logic [5:0]          row_index,
    input  logic [5:0]          col_index,
    input  logic signed [15:0]  element_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [5:0]          result_row,
    output logic [5:0]          result_col,
    output logic signed [37:0]  dot_product,
    output logic                last_of_row
);
    import imm_pkg::*;

    cmd_t    cmd;
    status_t st;

    imm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .row_index (row_index),
        .cmd       (cmd),
        .st        (st)
    );

    imm_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_row    (result_row),
        .result_col    (result_col),
        .dot_product   (dot_product),
        .last_of_row   (last_of_row)
    );

endmodule

@@ sv/imm_checker.sv @@
// imm_checker: port-level assertions for integer_matrix_multiply, with bind.
// Depends on imm_pkg.
module imm_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [1:0]          req_type,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [5:0]          result_row,
    input  logic [5:0]          result_col,
    input  logic signed [37:0]  dot_product,
    input  logic                last_of_row
);
    import imm_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(dot_product)
            && $stable(result_row) && $stable(result_col) && $stable(last_of_row))
        else $error("stalled result changed");

    // loads never make the block busy
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (req_type == REQ_LOAD_A || req_type == REQ_LOAD_B)
            |=> !in_stall)
        else $error("busy after load request");

    // a row in progress keeps new requests out
    a_row_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_row |-> in_stall)
        else $error("request taken mid-row");

    a_reset_out: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid in reset");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (.*);
